// File: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is held
`define MSE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Clocked assertion that also holds across reset
`define MSE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: sv/mse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mse_pkg;

    // Default sizing
    localparam int DEF_MAX_ITEMS  = 64;
    localparam int DEF_DATA_WIDTH = 32;

    // Fixed width of the value fields on the ports
    localparam int VAL_WIDTH = 32;

    // Input request
    typedef struct packed {
        logic signed [VAL_WIDTH-1:0] element;
        logic                        is_last;
    } t_in_item;

    // Result
    typedef struct packed {
        logic signed [VAL_WIDTH-1:0] sorted_value;
        logic                        end_of_set;
        logic                        overflow;
    } t_out_item;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MERGE,
        ST_DRAIN
    } t_state;

endpackage

`default_nettype wire

// File: sv/mse_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mse_ram
    import mse_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_ITEMS,
    parameter int WIDTH = DEF_DATA_WIDTH,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr_a,
    input  wire logic [AW-1:0]    i_rd_addr_b,
    output logic      [WIDTH-1:0] o_rd_data_a,
    output logic      [WIDTH-1:0] o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Two registered read ports
    always_ff @(posedge i_clk) begin
        o_rd_data_a <= r_mem[i_rd_addr_a];
        o_rd_data_b <= r_mem[i_rd_addr_b];
    end

endmodule

`default_nettype wire

// File: sv/merge_sort_engine_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Sorting engine. Requests are taken while start is high and busy is low, one
// per cycle during loading; a request with is_last closes the set and starts a
// stable ascending bottom-up merge sort that ping-pongs between two memories of
// MAX_ITEMS entries, each with two read ports and one write port. Each merge
// pass moves one value per cycle while merging, after a setup step that reads
// the heads of each run pair. Busy falls in the same cycle as the last result
// appears. The sorted values then leave as an unbroken burst, one o_strobe
// pulse per cycle, and the receiver cannot stall them: it must take every
// cycle in which o_strobe is high. Requests beyond MAX_ITEMS are dropped and
// flagged on the overflow field of every result of that set.
module merge_sort_engine_top
    import mse_pkg::*;
#(
    parameter int MAX_ITEMS  = DEF_MAX_ITEMS,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      start,
    input  wire t_in_item  i_request,
    output logic           busy,
    output logic           o_strobe,
    output t_out_item      o_result
);

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int SW = CW + 2;

    t_state r_state, n_state;

    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_k, n_k;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_mid, n_mid;
    logic [CW-1:0] r_hi, n_hi;
    logic [CW:0]   r_width, n_width;
    logic          r_src, n_src;
    logic          r_dropped, n_dropped;
    logic          r_out_valid, n_out_valid;
    logic          r_out_last, n_out_last;
    logic          r_out_ovf, n_out_ovf;

    logic [AW-1:0]         rd_addr_a, rd_addr_b, wr_addr;
    logic [DATA_WIDTH-1:0] wr_data, in_ext;
    logic [DATA_WIDTH-1:0] m0_rd_a, m0_rd_b, m1_rd_a, m1_rd_b;
    logic [DATA_WIDTH-1:0] head_a, head_b;
    logic                  we0, we1;
    logic                  accept, a_live, b_live, take_a;
    logic [SW-1:0]         k_ext, cnt_ext, sum_mid, sum_hi, seg_mid, seg_hi;
    logic [CW:0]           width_dbl;

    // Ping-pong stores: m0 is element_store, m1 the merge scratch
    mse_ram #(
        .DEPTH (MAX_ITEMS),
        .WIDTH (DATA_WIDTH),
        .AW    (AW)
    ) u_store (
        .i_clk       (i_clk),
        .i_we        (we0),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_a (m0_rd_a),
        .o_rd_data_b (m0_rd_b)
    );

    mse_ram #(
        .DEPTH (MAX_ITEMS),
        .WIDTH (DATA_WIDTH),
        .AW    (AW)
    ) u_scratch (
        .i_clk       (i_clk),
        .i_we        (we1),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_a (m1_rd_a),
        .o_rd_data_b (m1_rd_b)
    );

    // Heads of the two runs come from the current source memory
    assign head_a = r_src ? m1_rd_a : m0_rd_a;
    assign head_b = r_src ? m1_rd_b : m0_rd_b;

    assign in_ext = DATA_WIDTH'($signed(i_request.element));
    assign accept = start && (r_state == ST_IDLE);

    // Merge decision; ties go to the left run
    assign a_live = (r_i < r_mid);
    assign b_live = (r_j < r_hi);
    assign take_a = a_live && (!b_live || ($signed(head_a) <= $signed(head_b)));

    // Run pair bounds for the segment starting at r_k
    assign k_ext     = SW'(r_k);
    assign cnt_ext   = SW'(r_count);
    assign sum_mid   = k_ext + SW'(r_width);
    assign sum_hi    = k_ext + SW'({r_width, 1'b0});
    assign seg_mid   = (sum_mid < cnt_ext) ? sum_mid : cnt_ext;
    assign seg_hi    = (sum_hi < cnt_ext) ? sum_hi : cnt_ext;
    assign width_dbl = {r_width[CW-1:0], 1'b0};

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_k         <= '0;
            r_width     <= '0;
            r_src       <= 1'b0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
            r_out_ovf   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_k         <= n_k;
            r_width     <= n_width;
            r_src       <= n_src;
            r_dropped   <= n_dropped;
            r_out_valid <= n_out_valid;
            r_out_last  <= n_out_last;
            r_out_ovf   <= n_out_ovf;
        end
    end

    // Run pointers
    always_ff @(posedge i_clk) begin
        r_i   <= n_i;
        r_j   <= n_j;
        r_mid <= n_mid;
        r_hi  <= n_hi;
    end

    // Sequencer: load, merge passes, drain
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_k         = r_k;
        n_i         = r_i;
        n_j         = r_j;
        n_mid       = r_mid;
        n_hi        = r_hi;
        n_width     = r_width;
        n_src       = r_src;
        n_dropped   = r_dropped;
        n_out_valid = 1'b0;
        n_out_last  = 1'b0;
        n_out_ovf   = r_dropped;
        rd_addr_a   = r_k[AW-1:0];
        rd_addr_b   = r_k[AW-1:0];
        wr_addr     = r_k[AW-1:0];
        wr_data     = take_a ? head_a : head_b;
        we0         = 1'b0;
        we1         = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    // append while there is room, else flag the drop
                    if (r_count < CW'(MAX_ITEMS)) begin
                        we0     = 1'b1;
                        wr_addr = r_count[AW-1:0];
                        wr_data = in_ext;
                        n_count = r_count + 1'b1;
                    end else begin
                        n_dropped = 1'b1;
                    end
                    if (i_request.is_last) begin
                        n_src   = 1'b0;
                        n_width = (CW+1)'(1);
                        n_k     = '0;
                        n_state = (n_count > CW'(1)) ? ST_SETUP : ST_DRAIN;
                    end
                end
            end

            ST_SETUP: begin
                // fetch both run heads of the next segment
                n_i       = r_k;
                n_mid     = seg_mid[CW-1:0];
                n_j       = seg_mid[CW-1:0];
                n_hi      = seg_hi[CW-1:0];
                rd_addr_a = r_k[AW-1:0];
                rd_addr_b = seg_mid[AW-1:0];
                n_state   = ST_MERGE;
            end

            ST_MERGE: begin
                // one value per cycle into the other memory; source and
                // destination never coincide, so no forwarding is needed
                we0       = r_src;
                we1       = !r_src;
                n_i       = r_i + CW'(take_a);
                n_j       = r_j + CW'(!take_a);
                rd_addr_a = n_i[AW-1:0];
                rd_addr_b = n_j[AW-1:0];
                n_k       = r_k + 1'b1;
                if (n_k == r_hi) begin
                    if (r_hi == r_count) begin
                        // pass done: swap memories, double run width
                        n_width = width_dbl;
                        n_src   = !r_src;
                        n_k     = '0;
                        n_state = (width_dbl >= {1'b0, r_count}) ? ST_DRAIN : ST_SETUP;
                    end else begin
                        n_state = ST_SETUP;
                    end
                end
            end

            ST_DRAIN: begin
                // stream sorted values; data shows in the cycle after the read
                rd_addr_a   = r_k[AW-1:0];
                n_k         = r_k + 1'b1;
                n_out_valid = 1'b1;
                if (n_k == r_count) begin
                    n_out_last = 1'b1;
                    n_count    = '0;
                    n_dropped  = 1'b0;
                    n_k        = '0;
                    n_state    = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Ports
    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_out_valid;

    always_comb begin
        o_result.sorted_value = VAL_WIDTH'($signed(head_a));
        o_result.end_of_set   = r_out_last;
        o_result.overflow     = r_out_ovf;
    end

endmodule

`default_nettype wire

// File: sv/mse_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mse_checker
    import mse_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      busy,
    input  wire logic      o_strobe,
    input  wire t_out_item o_result
);

    // No result right after reset
    `MSE_ASSERT_ALWAYS(a_no_strobe_after_reset, i_clk, !i_rst_n |=> !o_strobe, "strobe after reset")

    // A result only follows a busy cycle
    `MSE_ASSERT(a_strobe_after_busy, i_clk, i_rst_n, o_strobe |-> $past(busy), "strobe while idle")

    // The end marker only rides on a strobe
    `MSE_ASSERT(a_end_needs_strobe, i_clk, i_rst_n, o_result.end_of_set |-> o_strobe, "stray end marker")

    // The final result frees the block
    `MSE_ASSERT(a_end_frees, i_clk, i_rst_n, (o_strobe && o_result.end_of_set) |-> !busy, "busy at end of set")

    // Burst is unbroken and the overflow flag is constant over a set
    `MSE_ASSERT(a_burst_steady, i_clk, i_rst_n, (o_strobe && !o_result.end_of_set) |=> (o_strobe && $stable(o_result.overflow)), "burst broken")

endmodule

bind merge_sort_engine_top mse_checker u_mse_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

`default_nettype wire

// File: tb/merge_sort_engine_top_tb.sv
`timescale 1ns / 1ps

module merge_sort_engine_top_tb;
    import mse_pkg::*;

    localparam int          CLK_PERIOD       = 12;
    localparam int          STORE_DEPTH      = DEF_MAX_ITEMS;
    localparam int          TARGET_REQUESTS  = 370;
    localparam int          SETTLE_CYCLES    = 24;
    localparam int unsigned RUN_LIMIT_CYCLES = 250_000;

    localparam logic signed [VAL_WIDTH-1:0] MAX_POS = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_WIDTH-1:0] MIN_NEG = 32'sh8000_0000;

    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      start     = 1'b0;
    t_in_item  i_request = '0;
    logic      busy;
    logic      o_strobe;
    t_out_item o_result;

    // Local copy of the engine state
    logic signed [VAL_WIDTH-1:0] loaded_vals[$];
    logic                        drop_seen = 1'b0;
    t_out_item                   expected_sorted[$];

    int fail_count    = 0;
    int requests_sent = 0;
    int sets_closed   = 0;
    int sets_overflow = 0;
    int values_seen   = 0;
    int burst_left    = 0;

    merge_sort_engine_top DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_request (i_request),
        .busy      (busy),
        .o_strobe  (o_strobe),
        .o_result  (o_result)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Store an accepted request; a closing request queues the whole set in order
    function automatic void load_request(input t_in_item req);
        logic signed [VAL_WIDTH-1:0] ordered[$];
        int                          pos;
        t_out_item                   res;
        if (loaded_vals.size() < STORE_DEPTH) begin
            loaded_vals.push_back(req.element);
        end else begin
            drop_seen = 1'b1;
        end
        if (req.is_last) begin
            // insertion after all equal values keeps arrival order on ties
            foreach (loaded_vals[i]) begin
                pos = ordered.size();
                while (pos > 0 && ordered[pos-1] > loaded_vals[i])
                    pos--;
                ordered.insert(pos, loaded_vals[i]);
            end
            foreach (ordered[k]) begin
                res.sorted_value = ordered[k];
                res.end_of_set   = (k == ordered.size() - 1);
                res.overflow     = drop_seen;
                expected_sorted.push_back(res);
            end
            sets_closed++;
            if (drop_seen)
                sets_overflow++;
            loaded_vals.delete();
            drop_seen = 1'b0;
        end
    endfunction

    // Random value, weighted toward extremes and a narrow range for ties
    function automatic logic signed [VAL_WIDTH-1:0] pick_value();
        logic signed [VAL_WIDTH-1:0] v;
        case ($urandom_range(0, 7))
            0:       v = MAX_POS;
            1:       v = MIN_NEG;
            2, 3:    v = $signed($urandom_range(0, 15)) - 8;
            default: v = $urandom();
        endcase
        return v;
    endfunction

    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Sender works in bursts with random gaps in between
    task automatic pace_sender();
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
                idle_cycles($urandom_range(1, 7));
        end
        burst_left--;
    endtask

    // Present one request and hold it until the engine takes it
    task automatic send_request(input logic signed [VAL_WIDTH-1:0] val,
                                input logic close_set);
        t_in_item req;
        req.element = val;
        req.is_last = close_set;
        pace_sender();
        start     <= 1'b1;
        i_request <= req;
        do @(posedge i_clk); while (busy !== 1'b0);
        requests_sent++;
        load_request(req);
    endtask

    // Hold off until every queued result has come out, then let it settle
    task automatic wait_results_drained();
        start <= 1'b0;
        while (expected_sorted.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_single_values();
        send_request(MAX_POS, 1'b1);
        send_request(MIN_NEG, 1'b1);
    endtask

    // Extremes, zero and repeated values in one set
    task automatic test_extremes_and_ties();
        logic signed [VAL_WIDTH-1:0] vals[9];
        vals = '{32'sd0, -32'sd1, MAX_POS, MIN_NEG, 32'sd1, -32'sd1, 32'sd0,
                 MAX_POS, MIN_NEG};
        foreach (vals[i])
            send_request(vals[i], i == 8);
    endtask

    task automatic test_ordered_inputs();
        for (int i = 0; i < 5; i++)
            send_request(-32'sd2 + i, i == 4);
        for (int i = 0; i < 5; i++)
            send_request(32'sd1000 - 100 * i, i == 4);
    endtask

    task automatic test_full_store();
        for (int i = 0; i < STORE_DEPTH; i++)
            send_request(pick_value(), i == STORE_DEPTH - 1);
    endtask

    // Requests past capacity are dropped, the closing one included
    task automatic test_overflow();
        for (int i = 0; i < STORE_DEPTH + 3; i++)
            send_request(pick_value(), i == STORE_DEPTH + 2);
    endtask

    task automatic test_random_sets();
        int set_len;
        int set_no;
        set_no = 0;
        while (requests_sent < TARGET_REQUESTS) begin
            case ($urandom_range(0, 29))
                0:       set_len = STORE_DEPTH;
                1:       set_len = STORE_DEPTH + $urandom_range(1, 4);
                default: set_len = $urandom_range(1, 12);
            endcase
            for (int i = 0; i < set_len; i++)
                send_request(pick_value(), i == set_len - 1);
            set_no++;
            // one mid-run pause with the engine fully emptied
            if (set_no == 6)
                wait_results_drained();
        end
    endtask

    // Check each result against the oldest queued one
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_strobe !== 1'b0) begin
            values_seen++;
            if (expected_sorted.size() == 0) begin
                $error("unexpected result: sorted_value %0d", o_result.sorted_value);
                fail_count++;
            end else begin
                want = expected_sorted.pop_front();
                if (o_result.sorted_value !== want.sorted_value) begin
                    $error("sorted_value mismatch: expected %0d, actual %0d",
                           want.sorted_value, o_result.sorted_value);
                    fail_count++;
                end
                if (o_result.end_of_set !== want.end_of_set) begin
                    $error("end_of_set mismatch: expected %0b, actual %0b",
                           want.end_of_set, o_result.end_of_set);
                    fail_count++;
                end
                if (o_result.overflow !== want.overflow) begin
                    $error("overflow mismatch: expected %0b, actual %0b",
                           want.overflow, o_result.overflow);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_values();
        test_extremes_and_ties();
        test_ordered_inputs();
        wait_results_drained();
        test_full_store();
        test_overflow();
        wait_results_drained();
        test_random_sets();
        wait_results_drained();

        if (expected_sorted.size() != 0) begin
            $error("%0d results never arrived", expected_sorted.size());
            fail_count++;
        end
        $display("Sorted %0d sets from %0d requests (%0d over capacity), %0d values checked.",
                 sets_closed, requests_sent, sets_overflow, values_seen);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(RUN_LIMIT_CYCLES * CLK_PERIOD);
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+sv
sv/mse_pkg.sv
sv/mse_ram.sv
sv/merge_sort_engine_top.sv
sv/mse_checker.sv
tb/merge_sort_engine_top_tb.sv
